### rtl/core/gta_pkg.sv
package gta_pkg;

    // field and register widths
    localparam int ALLELE_W   = 8;
    localparam int EFFECT_W   = 32;
    localparam int SUM_W      = 48;
    localparam int STRANDS_W  = 4;
    localparam int SCALE_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // strands beyond the allele field read as not set
    localparam int MAX_STRANDS  = 8;
    localparam int USED_STRANDS = (MAX_STRANDS < ALLELE_W) ? MAX_STRANDS : ALLELE_W;
    localparam int CNT_W        = $clog2(USED_STRANDS + 1);
    localparam int PAIR_W       = $clog2(USED_STRANDS / 2 + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRAND_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOIDY_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENVR_FACTOR  = 2'd2;

    localparam logic [STRANDS_W-1:0] STRAND_COUNT_RST = 4'd2;
    localparam logic [SCALE_W-1:0]   PLOIDY_SCALE_RST = 17'h10000;

    // shared multiply-accumulate unit
    localparam int MUL_A_W = 41;
    localparam int DIGIT_W = 18;
    localparam int MAC_W   = 72;
    localparam int BIAS_W  = 16;

    // rounding constants, preloaded on the first digit of an operation
    localparam logic [BIAS_W-1:0] BIAS_NONE   = 16'd0;
    localparam logic [BIAS_W-1:0] BIAS_SHR16  = 16'h8000;
    localparam logic [BIAS_W-1:0] BIAS_SHR24H = 16'd32;
    localparam logic [BIAS_W-1:0] BIAS_SHR25H = 16'd64;

    typedef struct packed {
        logic              en;
        logic              first;
        logic [BIAS_W-1:0] bias;
    } mac_ctrl_t;

endpackage

### rtl/core/gta_if.sv
interface gta_locus_if;
    logic                                valid;
    logic                                ready;
    logic [gta_pkg::ALLELE_W-1:0]        strand_alleles;
    logic signed [gta_pkg::EFFECT_W-1:0] additive_effect;
    logic signed [gta_pkg::EFFECT_W-1:0] dominance_factor;
    logic signed [gta_pkg::EFFECT_W-1:0] residual_effect;
    logic                                last_locus;

    modport source (
        output valid, strand_alleles, additive_effect, dominance_factor,
               residual_effect, last_locus,
        input  ready
    );
    modport sink (
        input  valid, strand_alleles, additive_effect, dominance_factor,
               residual_effect, last_locus,
        output ready
    );
endinterface

interface gta_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [gta_pkg::SUM_W-1:0] genetic_sum;
    logic signed [gta_pkg::SUM_W-1:0] residual_sum;

    modport source (
        output valid, genetic_sum, residual_sum,
        input  ready
    );
    modport sink (
        input  valid, genetic_sum, residual_sum,
        output ready
    );
endinterface

### rtl/core/gta_strand_count.sv
module gta_strand_count (
    input  logic [gta_pkg::ALLELE_W-1:0]  alleles,
    input  logic [gta_pkg::STRANDS_W-1:0] strand_count,
    output logic [gta_pkg::CNT_W-1:0]     count,
    output logic [gta_pkg::PAIR_W-1:0]    pairs
);

    logic [gta_pkg::ALLELE_W-1:0] in_range;

    always_comb
    begin
        for (int i = 0; i < gta_pkg::ALLELE_W; i++)
        begin
            in_range[i] = (int'(strand_count) > i) && (gta_pkg::MAX_STRANDS > i);
        end
    end

    always_comb
    begin
        count = '0;
        pairs = '0;
        for (int i = 0; i < gta_pkg::ALLELE_W; i++)
        begin
            count = count + gta_pkg::CNT_W'(alleles[i] & in_range[i]);
        end
        // a pair needs both strands in range, an odd last strand forms none
        for (int p = 0; p < gta_pkg::ALLELE_W / 2; p++)
        begin
            if (in_range[2*p+1] && (alleles[2*p] != alleles[2*p+1]))
            begin
                pairs = pairs + gta_pkg::PAIR_W'(1);
            end
        end
    end

endmodule

### rtl/core/gta_mac.sv
module gta_mac (
    input  logic                          clk,
    input  gta_pkg::mac_ctrl_t            ctrl,
    input  logic [gta_pkg::MUL_A_W-1:0]   op_a,
    input  logic [gta_pkg::DIGIT_W-1:0]   op_d,
    output logic [gta_pkg::MAC_W-1:0]     acc
);

    logic [gta_pkg::MUL_A_W+gta_pkg::DIGIT_W-1:0] prod;
    logic [gta_pkg::MAC_W-1:0]                    base;
    logic [gta_pkg::MAC_W-1:0]                    acc_reg;
    logic [gta_pkg::MAC_W-1:0]                    acc_next;

    assign prod = op_a * op_d;

    // digits come most significant first, so the running value shifts up one digit
    always_comb
    begin
        base     = ctrl.first ? gta_pkg::MAC_W'(ctrl.bias) : (acc_reg << gta_pkg::DIGIT_W);
        acc_next = base + gta_pkg::MAC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/core/genotype_trait_accumulator.sv
// Locus accumulator for one trait: each accepted item (one locus) adds a genetic and a residual
// term to two saturating 48-bit Q24.24 sums; the item marked last_locus returns both sums and
// clears them. Items are accepted only in the idle state and then run through eleven sequencer
// steps, nine of which drive the single 41x18 multiply-add unit that forms every product, wide
// operands one 18-bit digit a step. The result sits in an output register; a last locus waits
// in its final step only while the previous result is still untaken. The user must write
// registers via cfg_we/cfg_index/cfg_data only while no locus is in work; it is not enforced.
module genotype_trait_accumulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gta_pkg::CFG_DATA_W-1:0]   cfg_data,
    gta_locus_if.sink                        locus,
    gta_result_if.source                     result
);

    localparam int EFF_W    = gta_pkg::EFFECT_W;
    localparam int SUM_W    = gta_pkg::SUM_W;
    localparam int DIGIT_W  = gta_pkg::DIGIT_W;
    localparam int MUL_A_W  = gta_pkg::MUL_A_W;
    localparam int SCALE_SH = 16;
    localparam int FRAC_SH  = 24;
    localparam int HALF_SH  = 25;
    localparam int M1_W     = 35;
    localparam int G_MAG_W  = 36;
    localparam int FM_W     = 35;
    localparam int H_MAG_W  = 38;
    localparam int S_W      = 40;
    localparam int S_MAG_W  = 39;
    localparam int R_MAG_W  = 42;

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_ADD_CNT   = 12'b0000_0000_0010,
        S_SCALE_G   = 12'b0000_0000_0100,
        S_DOM_PAIRS = 12'b0000_0000_1000,
        S_ENVR_HI   = 12'b0000_0001_0000,
        S_ENVR_LO   = 12'b0000_0010_0000,
        S_GF_HI     = 12'b0000_0100_0000,
        S_GF_LO     = 12'b0000_1000_0000,
        S_GEN_SUM   = 12'b0001_0000_0000,
        S_RES_CNT   = 12'b0010_0000_0000,
        S_SCALE_R   = 12'b0100_0000_0000,
        S_RES_SUM   = 12'b1000_0000_0000
    } state_t;

    function automatic logic [EFF_W-1:0] magnitude(input logic [EFF_W-1:0] x);
        return x[EFF_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0] acc,
        input logic [SUM_W-1:0] mag,
        input logic             neg
    );
        logic [SUM_W+1:0] ext;
        logic [SUM_W+1:0] sum;
        ext = {2'b00, mag};
        if (neg)
        begin
            ext = ~ext + 1'b1;
        end
        sum = {{2{acc[SUM_W-1]}}, acc} + ext;
        if (sum[SUM_W+1:SUM_W-1] == 3'b000 || sum[SUM_W+1:SUM_W-1] == 3'b111)
        begin
            return sum[SUM_W-1:0];
        end
        else if (sum[SUM_W+1])
        begin
            return {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SUM_W-1){1'b1}}};
        end
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [gta_pkg::STRANDS_W-1:0] strand_count_reg;
    logic [gta_pkg::SCALE_W-1:0]   ploidy_scale_reg;
    logic [EFF_W-1:0]              envr_factor_reg;

    logic [gta_pkg::CNT_W-1:0]     count_in;
    logic [gta_pkg::PAIR_W-1:0]    pairs_in;
    logic [gta_pkg::CNT_W-1:0]     count_reg;
    logic [gta_pkg::PAIR_W-1:0]    pairs_reg;
    logic [EFF_W-1:0]              add_mag_reg;
    logic                          add_neg_reg;
    logic [EFF_W-1:0]              dom_mag_reg;
    logic                          dom_neg_reg;
    logic [EFF_W-1:0]              res_reg;
    logic [EFF_W-1:0]              res_mag_reg;
    logic [EFF_W-1:0]              envr_mag_reg;
    logic                          envr_neg_reg;
    logic                          last_reg;

    logic [G_MAG_W-1:0]            g_mag_reg;
    logic [FM_W-1:0]               fm_reg;
    logic [FM_W-1:0]               fm_next;
    logic                          fneg_reg;
    logic                          fneg_next;
    logic [H_MAG_W-1:0]            h_mag_reg;
    logic [S_W-1:0]                s_reg;
    logic [S_W-1:0]                s_next;
    logic [S_MAG_W-1:0]            s_mag_reg;
    logic                          s_neg_reg;

    logic [SUM_W-1:0]              genetic_acc_reg;
    logic [SUM_W-1:0]              residual_acc_reg;
    logic [SUM_W-1:0]              residual_new;

    logic                          out_valid_reg;
    logic [SUM_W-1:0]              out_genetic_reg;
    logic [SUM_W-1:0]              out_residual_reg;

    logic                          accept;
    logic                          res_stall;

    gta_pkg::mac_ctrl_t            mac_ctrl;
    logic [MUL_A_W-1:0]            mac_a;
    logic [DIGIT_W-1:0]            mac_d;
    logic [gta_pkg::MAC_W-1:0]     mac_acc;

    logic [M1_W:0]                 pd_minus_one;
    logic [M1_W-1:0]               pd;

    gta_strand_count u_strand_count (
        .alleles      (locus.strand_alleles),
        .strand_count (strand_count_reg),
        .count        (count_in),
        .pairs        (pairs_in)
    );

    gta_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_d (mac_d),
        .acc  (mac_acc)
    );

    assign locus.ready  = (state_reg == S_IDLE);
    assign accept       = locus.valid && locus.ready;
    assign res_stall    = last_reg && out_valid_reg && !result.ready;

    assign result.valid        = out_valid_reg;
    assign result.genetic_sum  = out_genetic_reg;
    assign result.residual_sum = out_residual_reg;

    // operand and digit selection for the shared unit
    always_comb
    begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_d    = '0;
        case (state_reg)
            S_ADD_CNT:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_a          = MUL_A_W'(add_mag_reg);
                mac_d          = DIGIT_W'(count_reg);
            end
            S_SCALE_G:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_ctrl.bias  = gta_pkg::BIAS_SHR16;
                mac_a          = MUL_A_W'(mac_acc[M1_W-1:0]);
                mac_d          = DIGIT_W'(ploidy_scale_reg);
            end
            S_DOM_PAIRS:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_a          = MUL_A_W'(dom_mag_reg);
                mac_d          = DIGIT_W'(pairs_reg);
            end
            S_ENVR_HI:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_ctrl.bias  = gta_pkg::BIAS_SHR25H;
                mac_a          = MUL_A_W'(envr_mag_reg);
                mac_d          = DIGIT_W'(res_mag_reg[EFF_W-1:DIGIT_W]);
            end
            S_ENVR_LO:
            begin
                mac_ctrl.en    = 1'b1;
                mac_a          = MUL_A_W'(envr_mag_reg);
                mac_d          = res_mag_reg[DIGIT_W-1:0];
            end
            S_GF_HI:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_ctrl.bias  = gta_pkg::BIAS_SHR24H;
                mac_a          = MUL_A_W'(g_mag_reg);
                mac_d          = DIGIT_W'(fm_reg[FM_W-1:DIGIT_W]);
            end
            S_GF_LO:
            begin
                mac_ctrl.en    = 1'b1;
                mac_a          = MUL_A_W'(g_mag_reg);
                mac_d          = fm_reg[DIGIT_W-1:0];
            end
            S_RES_CNT:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_a          = MUL_A_W'(s_mag_reg);
                mac_d          = DIGIT_W'(count_reg);
            end
            S_SCALE_R:
            begin
                mac_ctrl.en    = 1'b1;
                mac_ctrl.first = 1'b1;
                mac_ctrl.bias  = gta_pkg::BIAS_SHR16;
                mac_a          = mac_acc[MUL_A_W-1:0];
                mac_d          = DIGIT_W'(ploidy_scale_reg);
            end
            default:
            begin
                mac_ctrl = '0;
            end
        endcase
    end

    // dominance factor f = one + pairs*dom, kept as magnitude and sign
    always_comb
    begin
        pd           = mac_acc[M1_W-1:0];
        pd_minus_one = {1'b0, pd} - (M1_W+1)'(1 << FRAC_SH);
        if (!dom_neg_reg)
        begin
            fm_next   = pd + FM_W'(1 << FRAC_SH);
            fneg_next = 1'b0;
        end
        else if (!pd_minus_one[M1_W] && (pd_minus_one != '0))
        begin
            fm_next   = pd_minus_one[FM_W-1:0];
            fneg_next = 1'b1;
        end
        else
        begin
            fm_next   = FM_W'(1 << FRAC_SH) - pd;
            fneg_next = 1'b0;
        end
    end

    always_comb
    begin
        if (envr_neg_reg)
        begin
            s_next = {{(S_W-EFF_W){res_reg[EFF_W-1]}}, res_reg} - S_W'(h_mag_reg);
        end
        else
        begin
            s_next = {{(S_W-EFF_W){res_reg[EFF_W-1]}}, res_reg} + S_W'(h_mag_reg);
        end
        residual_new = sat_add(residual_acc_reg,
                               SUM_W'(mac_acc[SCALE_SH+R_MAG_W-1:SCALE_SH]), s_neg_reg);
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:      state_next = accept ? S_ADD_CNT : S_IDLE;
            S_ADD_CNT:   state_next = S_SCALE_G;
            S_SCALE_G:   state_next = S_DOM_PAIRS;
            S_DOM_PAIRS: state_next = S_ENVR_HI;
            S_ENVR_HI:   state_next = S_ENVR_LO;
            S_ENVR_LO:   state_next = S_GF_HI;
            S_GF_HI:     state_next = S_GF_LO;
            S_GF_LO:     state_next = S_GEN_SUM;
            S_GEN_SUM:   state_next = S_RES_CNT;
            S_RES_CNT:   state_next = S_SCALE_R;
            S_SCALE_R:   state_next = S_RES_SUM;
            S_RES_SUM:   state_next = res_stall ? S_RES_SUM : S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strand_count_reg <= gta_pkg::STRAND_COUNT_RST;
            ploidy_scale_reg <= gta_pkg::PLOIDY_SCALE_RST;
            envr_factor_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gta_pkg::CFG_STRAND_COUNT:
                    strand_count_reg <= cfg_data[gta_pkg::STRANDS_W-1:0];
                gta_pkg::CFG_PLOIDY_SCALE:
                    ploidy_scale_reg <= cfg_data[gta_pkg::SCALE_W-1:0];
                gta_pkg::CFG_ENVR_FACTOR:
                    envr_factor_reg  <= cfg_data[EFF_W-1:0];
                default:
                    strand_count_reg <= strand_count_reg;
            endcase
        end
    end

    // locus operands, taken apart into magnitude and sign on acceptance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_reg    <= count_in;
            pairs_reg    <= pairs_in;
            add_mag_reg  <= magnitude(locus.additive_effect);
            add_neg_reg  <= locus.additive_effect[EFF_W-1];
            dom_mag_reg  <= magnitude(locus.dominance_factor);
            dom_neg_reg  <= locus.dominance_factor[EFF_W-1];
            res_reg      <= locus.residual_effect;
            res_mag_reg  <= magnitude(locus.residual_effect);
            envr_mag_reg <= magnitude(envr_factor_reg);
            envr_neg_reg <= envr_factor_reg[EFF_W-1];
            last_reg     <= locus.last_locus;
        end
        if (state_reg == S_DOM_PAIRS)
        begin
            g_mag_reg <= mac_acc[SCALE_SH+G_MAG_W-1:SCALE_SH];
        end
        if (state_reg == S_ENVR_HI)
        begin
            fm_reg   <= fm_next;
            fneg_reg <= fneg_next;
        end
        if (state_reg == S_GF_HI)
        begin
            h_mag_reg <= mac_acc[HALF_SH+H_MAG_W-1:HALF_SH];
        end
        if (state_reg == S_GF_LO)
        begin
            s_reg <= s_next;
        end
        if (state_reg == S_GEN_SUM)
        begin
            s_mag_reg <= s_reg[S_W-1] ? S_MAG_W'(~s_reg + 1'b1) : s_reg[S_MAG_W-1:0];
            s_neg_reg <= s_reg[S_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            genetic_acc_reg  <= '0;
            residual_acc_reg <= '0;
        end
        else if (state_reg == S_GEN_SUM)
        begin
            genetic_acc_reg <= sat_add(genetic_acc_reg, mac_acc[FRAC_SH+SUM_W-1:FRAC_SH],
                                       add_neg_reg ^ fneg_reg);
        end
        else if (state_reg == S_RES_SUM && !res_stall)
        begin
            if (last_reg)
            begin
                genetic_acc_reg  <= '0;
                residual_acc_reg <= '0;
            end
            else
            begin
                residual_acc_reg <= residual_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_RES_SUM && last_reg && !res_stall)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RES_SUM && last_reg && !res_stall)
        begin
            out_genetic_reg  <= genetic_acc_reg;
            out_residual_reg <= residual_new;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_ADD_CNT)
        else $error("accepted item did not start the sequence");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == S_RES_SUM && last_reg))
        else $error("result shown without a finished last locus");

    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES_SUM && last_reg && !res_stall)
        |=> (genetic_acc_reg == '0 && residual_acc_reg == '0))
        else $error("sums not cleared after a result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES_SUM && res_stall)
        |=> (state_reg == S_RES_SUM && $stable(genetic_acc_reg) && $stable(mac_acc)))
        else $error("last locus lost its work while the result was held");

endmodule
